[sv/utf_pkg.sv]
package utf_pkg;

   localparam int SECONDS_WIDTH_DEF = 32;

   // 86400 > 2**16, so the day count of a W-bit value fits in W-16 bits
   localparam int DAY_SHIFT = 16;

   // trial remainder of the restoring divider: remainder (17 bits) plus one bit
   localparam int DIV_W      = 18;
   localparam int REM_W      = 17;
   localparam int HOUR_REM_W = 12;
   localparam int HOUR_W     = 5;
   localparam int MIN_W      = 6;

   localparam logic [DIV_W-1:0] DIV_DAY  = DIV_W'(86400);
   localparam logic [DIV_W-1:0] DIV_HOUR = DIV_W'(3600);
   localparam logic [DIV_W-1:0] DIV_MIN  = DIV_W'(60);

   localparam int NUM_DIGITS = 5;
   localparam int CHAR_W     = 7;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_D     = 7'h64;
   localparam logic [CHAR_W-1:0] CH_H     = 7'h68;
   localparam logic [CHAR_W-1:0] CH_M     = 7'h6d;
   localparam logic [CHAR_W-1:0] CH_S     = 7'h73;

   typedef struct packed {
      logic [HOUR_W-1:0] hours;
      logic [MIN_W-1:0]  minutes;
      logic [MIN_W-1:0]  secs;
   } utf_hms_type;

endpackage

[sv/utf_if.sv]
interface utf_req_if #(parameter int SECONDS_WIDTH = utf_pkg::SECONDS_WIDTH_DEF);
   logic                     valid;
   logic                     ready;
   logic [SECONDS_WIDTH-1:0] seconds;

   modport source (output valid, output seconds, input ready);
   modport sink (input valid, input seconds, output ready);
endinterface

interface utf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [utf_pkg::CHAR_W-1:0]    text_char;
   logic                          last;

   modport source (output valid, output text_char, output last, input ready);
   modport sink (input valid, input text_char, input last, output ready);
endinterface

[sv/uptime_text_formatter.sv]
// Uptime text formatter.
// req_chan carries one seconds count per item; rsp_chan returns the text
// "<d>d <h>h <m>m <s>s" one ASCII character per item, leading units left
// out while they and every higher unit are zero, last set on the 's'.
// Both channels use valid/ready; an item moves when both are high.
// An item is taken only while the block is idle, one at a time.
// Steps: the seconds value is split by a bit-serial restoring divider,
// one quotient bit per cycle, into days, hours, minutes and seconds.
// Each unit is then looked at in the select state: a skipped unit moves on to
// the next, a printed one goes through a bit-serial BCD pass and is sent as
// its digits, its letter and a space (none after the 's'), one character per
// cycle while the receiver is ready. At 32 bits the text runs to 18 characters
// at most. The next request can be taken once the sequencer is back in idle,
// after the last character is loaded.
// The character output is registered: when the receiver holds ready low the
// character waits in place and the sequencer pauses; a new request can be
// accepted while the final character is still waiting.
// Reset (synchronous) returns to idle and drops rsp valid.
module uptime_text_formatter #(
   parameter int SECONDS_WIDTH = utf_pkg::SECONDS_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   utf_req_if.sink    req_chan,
   utf_rsp_if.source  rsp_chan
);
   import utf_pkg::*;

   localparam int DAYS_W = SECONDS_WIDTH - DAY_SHIFT;
   localparam int BIN_W  = (DAYS_W > MIN_W) ? DAYS_W : MIN_W;
   localparam int BCNT_W = $clog2(BIN_W + 1);
   localparam int DIG_W  = $clog2(NUM_DIGITS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SPLIT  = 3'd1;
   localparam logic [2:0] ST_SELECT = 3'd2;
   localparam logic [2:0] ST_CONV   = 3'd3;
   localparam logic [2:0] ST_DIGIT  = 3'd4;
   localparam logic [2:0] ST_LETTER = 3'd5;
   localparam logic [2:0] ST_SPACE  = 3'd6;

   localparam logic [1:0] UNIT_DAY  = 2'd0;
   localparam logic [1:0] UNIT_HOUR = 2'd1;
   localparam logic [1:0] UNIT_MIN  = 2'd2;
   localparam logic [1:0] UNIT_SEC  = 2'd3;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        unit_ff, unit_in;
   logic [DIG_W-1:0]  dig_ff, dig_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;

   logic                   split_done;
   logic [DAYS_W-1:0]      days;
   utf_hms_type            hms;
   logic                   bcd_start;
   logic [BIN_W-1:0]       bcd_value;
   logic [BCNT_W-1:0]      bcd_nbits;
   logic                   bcd_done;
   logic [4*NUM_DIGITS-1:0] bcd_digits;

   logic              req_accept;
   logic              out_free;
   logic              day_nz, hour_nz, min_nz;
   logic              show;
   logic [CHAR_W-1:0] letter;
   logic [DIG_W-1:0]  lead;
   logic [3:0]        digit;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   utf_split #(.SECONDS_WIDTH(SECONDS_WIDTH)) u_split (
      .clock   (clock),
      .reset   (reset),
      .start   (req_accept),
      .seconds (req_chan.seconds),
      .done    (split_done),
      .days    (days),
      .hms     (hms)
   );

   utf_bcd #(.BIN_W(BIN_W)) u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (bcd_value),
      .nbits  (bcd_nbits),
      .done   (bcd_done),
      .digits (bcd_digits)
   );

   assign day_nz  = (days != '0);
   assign hour_nz = (hms.hours != '0);
   assign min_nz  = (hms.minutes != '0);

   // converter input is left-aligned so only the unit's own bits are shifted
   always_comb begin
      unique case (unit_ff)
         UNIT_DAY: begin
            show      = day_nz;
            bcd_value = BIN_W'(days) << (BIN_W - DAYS_W);
            bcd_nbits = BCNT_W'(DAYS_W);
            letter    = CH_D;
         end
         UNIT_HOUR: begin
            show      = day_nz || hour_nz;
            bcd_value = BIN_W'(hms.hours) << (BIN_W - HOUR_W);
            bcd_nbits = BCNT_W'(HOUR_W);
            letter    = CH_H;
         end
         UNIT_MIN: begin
            show      = day_nz || hour_nz || min_nz;
            bcd_value = BIN_W'(hms.minutes) << (BIN_W - MIN_W);
            bcd_nbits = BCNT_W'(MIN_W);
            letter    = CH_M;
         end
         default: begin
            show      = 1'b1;
            bcd_value = BIN_W'(hms.secs) << (BIN_W - MIN_W);
            bcd_nbits = BCNT_W'(MIN_W);
            letter    = CH_S;
         end
      endcase
   end

   // highest nonzero digit; zero prints as a single '0'
   always_comb begin
      lead = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_digits[4*i +: 4] != 4'd0) begin
            lead = DIG_W'(i);
         end
      end
   end

   assign digit = bcd_digits[4*dig_ff +: 4];

   always_comb begin
      state_in     = state_ff;
      unit_in      = unit_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      bcd_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (split_done) begin
               unit_in  = UNIT_DAY;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (show) begin
               bcd_start = 1'b1;
               state_in  = ST_CONV;
            end else begin
               unit_in = unit_ff + 1'b1;
            end
         end
         ST_CONV: begin
            if (bcd_done) begin
               dig_in   = lead;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CH_ZERO | CHAR_W'(digit);
               last_in      = 1'b0;
               if (dig_ff == '0) begin
                  state_in = ST_LETTER;
               end else begin
                  dig_in = dig_ff - 1'b1;
               end
            end
         end
         ST_LETTER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = letter;
               last_in      = (unit_ff == UNIT_SEC);
               state_in     = (unit_ff == UNIT_SEC) ? ST_IDLE : ST_SPACE;
            end
         end
         ST_SPACE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CH_SPACE;
               last_in      = 1'b0;
               unit_in      = unit_ff + 1'b1;
               state_in     = ST_SELECT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      unit_ff <= unit_in;
      dig_ff  <= dig_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.text_char = char_ff;
   assign rsp_chan.last      = last_ff;

   a_last_is_s: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last |-> rsp_chan.text_char == CH_S)
      else $error("last flag on a character other than 's'");

   a_accept_starts_split: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_SPLIT)
      else $error("accepted item did not start the divider");

   a_split_done_state: assert property (@(posedge clock) disable iff (reset)
      split_done |-> state_ff == ST_SPLIT)
      else $error("divider finished outside the split state");

   a_bcd_done_state: assert property (@(posedge clock) disable iff (reset)
      bcd_done |-> state_ff == ST_CONV)
      else $error("converter finished outside the convert state");

endmodule

[sv/utf_split.sv]
module utf_split #(
   parameter int SECONDS_WIDTH = utf_pkg::SECONDS_WIDTH_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [SECONDS_WIDTH-1:0]                       seconds,
   output logic                                           done,
   output logic [SECONDS_WIDTH-utf_pkg::DAY_SHIFT-1:0]    days,
   output utf_pkg::utf_hms_type                           hms
);
   import utf_pkg::*;

   localparam int DAYS_W = SECONDS_WIDTH - DAY_SHIFT;
   localparam int CNT_W  = $clog2(SECONDS_WIDTH);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DAY  = 2'd1;
   localparam logic [1:0] PH_HOUR = 2'd2;
   localparam logic [1:0] PH_MIN  = 2'd3;

   logic [1:0]               phase_ff, phase_in;
   logic                     done_ff, done_in;
   logic [SECONDS_WIDTH-1:0] dvd_ff, dvd_in;
   logic [SECONDS_WIDTH-1:0] q_ff, q_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DAYS_W-1:0]        days_ff, days_in;
   utf_hms_type              hms_ff, hms_in;

   logic [DIV_W-1:0]         divisor;
   logic [DIV_W-1:0]         trial;
   logic [DIV_W-1:0]         diff;
   logic                     ge;
   logic [REM_W-1:0]         rem_step;
   logic [SECONDS_WIDTH-1:0] q_step;

   always_comb begin
      unique case (phase_ff)
         PH_DAY:  divisor = DIV_DAY;
         PH_HOUR: divisor = DIV_HOUR;
         default: divisor = DIV_MIN;
      endcase
   end

   // one restoring step: bring down the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, dvd_ff[SECONDS_WIDTH-1]};
   assign ge       = trial >= divisor;
   assign diff     = trial - divisor;
   assign rem_step = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
   assign q_step   = {q_ff[SECONDS_WIDTH-2:0], ge};

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      dvd_in   = dvd_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      days_in  = days_ff;
      hms_in   = hms_ff;
      if (phase_ff == PH_IDLE) begin
         if (start) begin
            phase_in = PH_DAY;
            dvd_in   = seconds;
            rem_in   = '0;
            q_in     = '0;
            cnt_in   = CNT_W'(SECONDS_WIDTH - 1);
         end
      end else begin
         dvd_in = dvd_ff << 1;
         rem_in = rem_step;
         q_in   = q_step;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            rem_in = '0;
            q_in   = '0;
            unique case (phase_ff)
               PH_DAY: begin
                  days_in  = q_step[DAYS_W-1:0];
                  dvd_in   = SECONDS_WIDTH'(rem_step) << (SECONDS_WIDTH - REM_W);
                  cnt_in   = CNT_W'(REM_W - 1);
                  phase_in = PH_HOUR;
               end
               PH_HOUR: begin
                  hms_in.hours = q_step[HOUR_W-1:0];
                  dvd_in       = SECONDS_WIDTH'(rem_step[HOUR_REM_W-1:0])
                                 << (SECONDS_WIDTH - HOUR_REM_W);
                  cnt_in       = CNT_W'(HOUR_REM_W - 1);
                  phase_in     = PH_MIN;
               end
               default: begin
                  hms_in.minutes = q_step[MIN_W-1:0];
                  hms_in.secs    = rem_step[MIN_W-1:0];
                  phase_in       = PH_IDLE;
                  done_in        = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      dvd_ff  <= dvd_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      days_ff <= days_in;
      hms_ff  <= hms_in;
   end

   assign done = done_ff;
   assign days = days_ff;
   assign hms  = hms_ff;

endmodule

[sv/utf_bcd.sv]
module utf_bcd #(
   parameter int BIN_W = utf_pkg::MIN_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [BIN_W-1:0]                     value,
   input  logic [$clog2(BIN_W+1)-1:0]           nbits,
   output logic                                 done,
   output logic [4*utf_pkg::NUM_DIGITS-1:0]     digits
);
   import utf_pkg::*;

   localparam int BCNT_W = $clog2(BIN_W + 1);
   localparam int BCD_W  = 4 * NUM_DIGITS;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCNT_W-1:0]  cnt_ff, cnt_in;
   logic [BCD_W-1:0]   adj;

   // add 3 to every digit of 5 or more before the shift (double dabble)
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      if (busy_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[BIN_W-1]};
         bin_in = bin_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         bin_in  = value;
         bcd_in  = '0;
         cnt_in  = nbits - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule
